// ----- rtl/core/fwt_pkg.sv -----
// Package for the forwarding watchdog tracker: sizes, codes and table word types.
package fwt_pkg;

  localparam int PEND_DEPTH  = 32;
  localparam int SUSP_DEPTH  = 32;
  localparam int MAX_RESULTS = 32;

  localparam int PIW = $clog2(PEND_DEPTH);
  localparam int SIW = $clog2(SUSP_DEPTH);
  localparam int XIW = (PIW > SIW) ? PIW : SIW;
  localparam int CW  = XIW + 1;
  localparam int NW  = $clog2(MAX_RESULTS);

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_HEARD  = 2'd1,
    OP_CHECK  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_RECORDED   = 3'd0,
    ST_SKIPPED    = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_CLEARED    = 3'd3,
    ST_NOT_FOUND  = 3'd4,
    ST_EXPIRED    = 3'd5,
    ST_NONE_EXP   = 3'd6,
    ST_SCORE_FULL = 3'd7
  } status_t;

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_THRESH  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PSCAN,
    S_SSCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [31:0] uid;
    logic [31:0] stamp;
    logic [31:0] fwd;
  } pend_word_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [7:0]  count;
  } score_word_t;

endpackage

// ----- rtl/core/forwarding_watchdog_tracker.sv -----
// Forwarding watchdog tracker: pending packet table and forwarder score table.
// A record runs a score scan then a pending scan, an overheard a pending scan;
// each expiry of a check costs a pending scan plus a score scan.
// Throughput: one item at a time; set by the one-entry-per-cycle memory scans.
// Reset: synchronous active-low; clears valid, blacklist and control state, loads
// timeout 2000 and threshold 10. Table memories need no clearing pass.
module forwarding_watchdog_tracker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_opcode,
  input  logic [31:0]          in_packet_uid,
  input  logic [31:0]          in_next_hop_addr,
  input  logic [31:0]          in_current_time,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_status,
  output logic [31:0]          out_suspect_addr,
  output logic [7:0]           out_suspect_score,
  output logic                 out_suspect_blacklisted,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic                 cfg_idx,
  input  logic [31:0]          cfg_wdata
);
  import fwt_pkg::*;

  // Table memories: one read port with registered data, one write port.
  pend_word_t  pend_mem [PEND_DEPTH];
  score_word_t score_mem [SUSP_DEPTH];
  pend_word_t  pend_rd_r;
  score_word_t score_rd_r;

  logic                  pend_we;
  logic [PIW-1:0]        pend_wa;
  pend_word_t            pend_wd;
  logic                  score_we;
  logic [SIW-1:0]        score_wa;
  score_word_t           score_wd;

  // Valid and blacklist bits live in flops so reset clears them at once.
  logic [PEND_DEPTH-1:0] pv_r, pv_nxt;
  logic [SUSP_DEPTH-1:0] sv_r, sv_nxt;
  logic [SUSP_DEPTH-1:0] bl_r, bl_nxt;

  logic [31:0] timeout_r;
  logic [7:0]  thr_r;

  state_t      state_r, state_nxt, after_r, after_nxt;
  opcode_t     op_r, op_nxt;
  logic [31:0] uid_r, uid_nxt, hop_r, hop_nxt, now_r, now_nxt;

  // Scan control: issue counter, then the data slot registered behind it.
  logic [CW-1:0]  iss_r, iss_nxt;
  logic           dv_r, dv_nxt;
  logic [XIW-1:0] di_r, di_nxt;

  logic           found_r, found_nxt, free_found_r, free_found_nxt;
  logic [XIW-1:0] hit_r, hit_nxt, free_r, free_nxt;
  logic [7:0]     sc_cnt_r, sc_cnt_nxt;
  logic [PIW:0]   exp_cnt_r, exp_cnt_nxt;
  logic           best_found_r, best_found_nxt;
  logic [PIW-1:0] best_r, best_nxt;
  logic [31:0]    best_uid_r, best_uid_nxt, best_fwd_r, best_fwd_nxt;
  logic [NW-1:0]  n_r, n_nxt;

  // Pending result, waiting for the output register.
  status_t     res_st_r, res_st_nxt;
  logic [31:0] res_addr_r, res_addr_nxt;
  logic [7:0]  res_score_r, res_score_nxt;
  logic        res_bl_r, res_bl_nxt, res_last_r, res_last_nxt;

  logic        ov_r, ov_nxt;
  status_t     o_st_r, o_st_nxt;
  logic [31:0] o_addr_r, o_addr_nxt;
  logic [7:0]  o_score_r, o_score_nxt;
  logic        o_bl_r, o_bl_nxt, o_last_r, o_last_nxt;

  logic [XIW-1:0] rd_idx;
  logic [31:0]    key_addr;
  logic [31:0]    age;
  logic           p_valid, s_valid, is_exp;
  logic           pscan_done, sscan_done;
  logic [7:0]     new_cnt;
  logic           last_exp;

  assign rd_idx   = iss_r[XIW-1:0];
  assign key_addr = (op_r == OP_CHECK) ? best_fwd_r : hop_r;
  assign age      = now_r - pend_rd_r.stamp;
  assign p_valid  = pv_r[di_r[PIW-1:0]];
  assign s_valid  = sv_r[di_r[SIW-1:0]];
  assign is_exp   = p_valid && (age > timeout_r);
  assign pscan_done = !dv_r && (iss_r == CW'(PEND_DEPTH));
  assign sscan_done = !dv_r && (iss_r == CW'(SUSP_DEPTH));
  assign new_cnt  = (sc_cnt_r == 8'hFF) ? 8'hFF : sc_cnt_r + 8'd1;
  // Final expiry when this is the only expired entry left or the result cap is hit.
  assign last_exp = (exp_cnt_r == (PIW+1)'(1)) || (n_r == NW'(MAX_RESULTS - 1));

  always_ff @(posedge clk) begin
    pend_rd_r  <= pend_mem[rd_idx[PIW-1:0]];
    score_rd_r <= score_mem[rd_idx[SIW-1:0]];
    if (pend_we) begin
      pend_mem[pend_wa] <= pend_wd;
    end
    if (score_we) begin
      score_mem[score_wa] <= score_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= 32'd2000;
      thr_r     <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TIMEOUT: timeout_r <= cfg_wdata;
        REG_THRESH:  thr_r     <= cfg_wdata[7:0];
        default:     timeout_r <= timeout_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      after_r <= S_IDLE;
      pv_r    <= '0;
      sv_r    <= '0;
      bl_r    <= '0;
      ov_r    <= 1'b0;
      dv_r    <= 1'b0;
      iss_r   <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
      pv_r    <= pv_nxt;
      sv_r    <= sv_nxt;
      bl_r    <= bl_nxt;
      ov_r    <= ov_nxt;
      dv_r    <= dv_nxt;
      iss_r   <= iss_nxt;
      n_r     <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    uid_r        <= uid_nxt;
    hop_r        <= hop_nxt;
    now_r        <= now_nxt;
    di_r         <= di_nxt;
    found_r      <= found_nxt;
    hit_r        <= hit_nxt;
    free_found_r <= free_found_nxt;
    free_r       <= free_nxt;
    sc_cnt_r     <= sc_cnt_nxt;
    exp_cnt_r    <= exp_cnt_nxt;
    best_found_r <= best_found_nxt;
    best_r       <= best_nxt;
    best_uid_r   <= best_uid_nxt;
    best_fwd_r   <= best_fwd_nxt;
    res_st_r     <= res_st_nxt;
    res_addr_r   <= res_addr_nxt;
    res_score_r  <= res_score_nxt;
    res_bl_r     <= res_bl_nxt;
    res_last_r   <= res_last_nxt;
    o_st_r       <= o_st_nxt;
    o_addr_r     <= o_addr_nxt;
    o_score_r    <= o_score_nxt;
    o_bl_r       <= o_bl_nxt;
    o_last_r     <= o_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    after_nxt      = after_r;
    op_nxt         = op_r;
    uid_nxt        = uid_r;
    hop_nxt        = hop_r;
    now_nxt        = now_r;
    pv_nxt         = pv_r;
    sv_nxt         = sv_r;
    bl_nxt         = bl_r;
    iss_nxt        = iss_r;
    dv_nxt         = 1'b0;
    di_nxt         = di_r;
    found_nxt      = found_r;
    hit_nxt        = hit_r;
    free_found_nxt = free_found_r;
    free_nxt       = free_r;
    sc_cnt_nxt     = sc_cnt_r;
    exp_cnt_nxt    = exp_cnt_r;
    best_found_nxt = best_found_r;
    best_nxt       = best_r;
    best_uid_nxt   = best_uid_r;
    best_fwd_nxt   = best_fwd_r;
    n_nxt          = n_r;
    res_st_nxt     = res_st_r;
    res_addr_nxt   = res_addr_r;
    res_score_nxt  = res_score_r;
    res_bl_nxt     = res_bl_r;
    res_last_nxt   = res_last_r;
    ov_nxt         = ov_r && out_stall;
    o_st_nxt       = o_st_r;
    o_addr_nxt     = o_addr_r;
    o_score_nxt    = o_score_r;
    o_bl_nxt       = o_bl_r;
    o_last_nxt     = o_last_r;
    pend_we        = 1'b0;
    pend_wa        = '0;
    pend_wd        = '{uid: uid_r, stamp: now_r, fwd: hop_r};
    score_we       = 1'b0;
    score_wa       = '0;
    score_wd       = '{addr: key_addr, count: new_cnt};
    in_stall       = (state_r != S_IDLE);

    // Clear the per-scan trackers whenever a scan starts.
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = opcode_t'(in_opcode);
          uid_nxt        = in_packet_uid;
          hop_nxt        = in_next_hop_addr;
          now_nxt        = in_current_time;
          iss_nxt        = '0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          exp_cnt_nxt    = '0;
          best_found_nxt = 1'b0;
          n_nxt          = '0;
          case (opcode_t'(in_opcode))
            OP_RECORD: state_nxt = S_SSCAN;
            OP_HEARD:  state_nxt = S_PSCAN;
            OP_CHECK:  state_nxt = S_PSCAN;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end

      S_PSCAN: begin
        if (iss_r < CW'(PEND_DEPTH)) begin
          iss_nxt = iss_r + CW'(1);
          dv_nxt  = 1'b1;
          di_nxt  = rd_idx;
        end
        if (dv_r) begin
          if (op_r == OP_CHECK) begin
            if (is_exp) begin
              exp_cnt_nxt = exp_cnt_r + (PIW+1)'(1);
              if (!best_found_r || (pend_rd_r.uid < best_uid_r)) begin
                best_found_nxt = 1'b1;
                best_nxt       = di_r[PIW-1:0];
                best_uid_nxt   = pend_rd_r.uid;
                best_fwd_nxt   = pend_rd_r.fwd;
              end
            end
          end else begin
            if (p_valid && (pend_rd_r.uid == uid_r) && !found_r) begin
              found_nxt = 1'b1;
              hit_nxt   = di_r;
            end
            if (!p_valid && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_nxt       = di_r;
            end
          end
        end
        if (pscan_done) begin
          res_addr_nxt  = '0;
          res_score_nxt = '0;
          res_bl_nxt    = 1'b0;
          res_last_nxt  = 1'b1;
          after_nxt     = S_IDLE;
          state_nxt     = S_EMIT;
          case (op_r)
            OP_RECORD: begin
              if (found_r || free_found_r) begin
                pend_we = 1'b1;
                pend_wa = found_r ? hit_r[PIW-1:0] : free_r[PIW-1:0];
                pv_nxt[pend_wa] = 1'b1;
                res_st_nxt = ST_RECORDED;
              end else begin
                res_st_nxt = ST_TABLE_FULL;
              end
            end
            OP_HEARD: begin
              if (found_r) begin
                pv_nxt[hit_r[PIW-1:0]] = 1'b0;
                res_st_nxt = ST_CLEARED;
              end else begin
                res_st_nxt = ST_NOT_FOUND;
              end
            end
            default: begin
              if (best_found_r) begin
                // Drop the expired entry with the lowest uid, then look up its forwarder.
                pv_nxt[best_r] = 1'b0;
                iss_nxt        = '0;
                found_nxt      = 1'b0;
                free_found_nxt = 1'b0;
                state_nxt      = S_SSCAN;
              end else begin
                res_st_nxt = ST_NONE_EXP;
              end
            end
          endcase
        end
      end

      S_SSCAN: begin
        if (iss_r < CW'(SUSP_DEPTH)) begin
          iss_nxt = iss_r + CW'(1);
          dv_nxt  = 1'b1;
          di_nxt  = rd_idx;
        end
        if (dv_r) begin
          if (s_valid && (score_rd_r.addr == key_addr) && !found_r) begin
            found_nxt  = 1'b1;
            hit_nxt    = di_r;
            sc_cnt_nxt = score_rd_r.count;
          end
          if (!s_valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_nxt       = di_r;
          end
        end
        if (sscan_done) begin
          res_addr_nxt  = '0;
          res_score_nxt = '0;
          res_bl_nxt    = 1'b0;
          res_last_nxt  = 1'b1;
          if (op_r == OP_RECORD) begin
            if (found_r && bl_r[hit_r[SIW-1:0]]) begin
              res_st_nxt = ST_SKIPPED;
              after_nxt  = S_IDLE;
              state_nxt  = S_EMIT;
            end else begin
              iss_nxt        = '0;
              found_nxt      = 1'b0;
              free_found_nxt = 1'b0;
              state_nxt      = S_PSCAN;
            end
          end else begin
            res_addr_nxt = best_fwd_r;
            res_last_nxt = last_exp;
            if (found_r) begin
              score_we = 1'b1;
              score_wa = hit_r[SIW-1:0];
              bl_nxt[score_wa] = bl_r[score_wa] || (new_cnt > thr_r);
              res_st_nxt    = ST_EXPIRED;
              res_score_nxt = new_cnt;
              res_bl_nxt    = bl_nxt[score_wa];
            end else if (free_found_r) begin
              score_we = 1'b1;
              score_wa = free_r[SIW-1:0];
              score_wd = '{addr: key_addr, count: 8'd1};
              sv_nxt[score_wa] = 1'b1;
              bl_nxt[score_wa] = (8'd1 > thr_r);
              res_st_nxt    = ST_EXPIRED;
              res_score_nxt = 8'd1;
              res_bl_nxt    = (8'd1 > thr_r);
            end else begin
              res_st_nxt = ST_SCORE_FULL;
            end
            // Advance to the next expiry unless this one closes the check.
            if (last_exp) begin
              after_nxt = S_IDLE;
            end else begin
              after_nxt      = S_PSCAN;
              n_nxt          = n_r + NW'(1);
              iss_nxt        = '0;
              exp_cnt_nxt    = '0;
              best_found_nxt = 1'b0;
            end
            state_nxt = S_EMIT;
          end
        end
      end

      S_EMIT: begin
        // Hold the result until the output register is free.
        if (!ov_r || !out_stall) begin
          ov_nxt      = 1'b1;
          o_st_nxt    = res_st_r;
          o_addr_nxt  = res_addr_r;
          o_score_nxt = res_score_r;
          o_bl_nxt    = res_bl_r;
          o_last_nxt  = res_last_r;
          state_nxt   = after_r;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid               = ov_r;
  assign out_status              = o_st_r;
  assign out_suspect_addr        = o_addr_r;
  assign out_suspect_score       = o_score_r;
  assign out_suspect_blacklisted = o_bl_r;
  assign out_last                = o_last_r;

endmodule
